FILE: sv/tpc_pkg.sv
// Shared types, widths and constants of the triangle plane clipper.
package tpc_pkg;

    localparam int CW       = 32;               // coordinate width, Q16.16
    localparam int NW       = 32;               // normal and offset register width
    localparam int NF       = 30;               // fraction bits of the normal
    localparam int PW       = NW + CW;          // one normal * coordinate product
    localparam int DW       = PW + 2;           // signed distance, sum of four terms
    localparam int QW       = 32;               // fraction bits of the edge parameter
    localparam int DIV_BITS = 2;                // quotient bits per divider stage
    localparam int DIV_STAGES = QW / DIV_BITS;
    localparam int CUT_LAT  = DIV_STAGES + 3;   // input, divide, multiply, add stages
    localparam int COLOR_W  = 24;
    localparam int AW       = 4;                // APB byte address width
    localparam int RW       = 2;                // register index width

    localparam logic [RW-1:0] REG_NORMAL_X = 2'd0;
    localparam logic [RW-1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [RW-1:0] REG_NORMAL_Z = 2'd2;
    localparam logic [RW-1:0] REG_OFFSET   = 2'd3;

    localparam logic [NW-1:0] NZ_RESET = NW'(1) << NF;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed {
        coord_t               a_x;
        coord_t               a_y;
        coord_t               a_z;
        coord_t               b_x;
        coord_t               b_y;
        coord_t               b_z;
        coord_t               c_x;
        coord_t               c_y;
        coord_t               c_z;
        logic [COLOR_W-1:0]   tri_color;
        logic                 model_end;
    } item_t;

    typedef struct packed {
        coord_t               out_a_x;
        coord_t               out_a_y;
        coord_t               out_a_z;
        coord_t               out_b_x;
        coord_t               out_b_y;
        coord_t               out_b_z;
        coord_t               out_c_x;
        coord_t               out_c_y;
        coord_t               out_c_z;
        logic [COLOR_W-1:0]   out_color;
        logic                 run_last;
    } result_t;

    typedef enum logic [1:0] {
        MODE_CULL,
        MODE_PASS,
        MODE_ONE,
        MODE_TWO
    } mode_t;

    function automatic coord_t coord_at(vertex_t v, int i);
        coord_t c;
        case (i)
            0:       c = v.x;
            1:       c = v.y;
            default: c = v.z;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/tpc_cut.sv
// Pipelined edge-plane intersection: restoring divide, scale and saturate.
module tpc_cut (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    input  tpc_pkg::vertex_t p,
    input  tpc_pkg::vertex_t q,
    input  tpc_pkg::dist_t   d0,
    input  tpc_pkg::dist_t   d1,
    output logic            done,
    output tpc_pkg::vertex_t e
);
    import tpc_pkg::*;

    localparam int VW  = DW + 1;        // divisor and remainder width
    localparam int MW  = CW + 1;        // delta magnitude width
    localparam int PRW = MW + QW;       // scaled step product width
    localparam int SW  = CW + 3;        // unsaturated result width

    function automatic logic [VW:0] div_step(logic [VW-1:0] r, logic [VW-1:0] d);
        logic [VW:0] r2;
        logic [VW:0] diff;
        r2   = {r, 1'b0};
        diff = r2 - {1'b0, d};
        if (r2 >= {1'b0, d})
            return {1'b1, diff[VW-1:0]};
        else
            return {1'b0, r2[VW-1:0]};
    endfunction

    // divider pipeline, index 0 is the input stage
    logic            vld_reg [DIV_STAGES+1];
    logic [VW-1:0]   rem_reg [DIV_STAGES+1];
    logic [VW-1:0]   den_reg [DIV_STAGES+1];
    logic [QW-1:0]   quo_reg [DIV_STAGES+1];
    vertex_t         p_reg   [DIV_STAGES+1];
    logic [MW-1:0]   mag_reg [DIV_STAGES+1][3];
    logic [2:0]      neg_reg [DIV_STAGES+1];

    logic signed [MW-1:0] delta [3];
    logic [MW-1:0]        mag_next [3];
    logic [2:0]           neg_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            delta[a]    = MW'(coord_at(q, a)) - MW'(coord_at(p, a));
            neg_next[a] = delta[a][MW-1];
            mag_next[a] = neg_next[a] ? MW'(-delta[a]) : MW'(delta[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= valid;
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= {d0[DW-1], d0} - {d1[DW-1], d1};
        rem_reg[0] <= {d0[DW-1], d0};
        quo_reg[0] <= '0;
        p_reg[0]   <= p;
        neg_reg[0] <= neg_next;
        for (int a = 0; a < 3; a++)
            mag_reg[0][a] <= mag_next[a];
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic [VW-1:0] r_c [DIV_BITS+1];
        logic [QW-1:0] q_c [DIV_BITS+1];
        logic [VW:0]   st  [DIV_BITS];

        always_comb
        begin
            r_c[0] = rem_reg[s];
            q_c[0] = quo_reg[s];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                st[b]    = div_step(r_c[b], den_reg[s]);
                r_c[b+1] = st[b][VW-1:0];
                q_c[b+1] = {q_c[b][QW-2:0], st[b][VW]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= r_c[DIV_BITS];
            quo_reg[s+1] <= q_c[DIV_BITS];
            den_reg[s+1] <= den_reg[s];
            p_reg[s+1]   <= p_reg[s];
            neg_reg[s+1] <= neg_reg[s];
            for (int a = 0; a < 3; a++)
                mag_reg[s+1][a] <= mag_reg[s][a];
        end
    end

    // scale stage: |delta| * t
    logic             mul_vld_reg;
    logic [PRW-1:0]   prod_reg [3];
    vertex_t          mul_p_reg;
    logic [2:0]       mul_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else
            mul_vld_reg <= vld_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
            prod_reg[a] <= PRW'(mag_reg[DIV_STAGES][a]) * PRW'(quo_reg[DIV_STAGES]);
        mul_p_reg   <= p_reg[DIV_STAGES];
        mul_neg_reg <= neg_reg[DIV_STAGES];
    end

    // add truncated step and saturate
    logic              out_vld_reg;
    coord_t            res_reg  [3];
    coord_t            res_next [3];
    logic signed [SW-1:0] sum   [3];
    logic [MW-1:0]     step     [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            step[a] = prod_reg[a][PRW-1:QW];
            sum[a]  = mul_neg_reg[a] ? SW'(coord_at(mul_p_reg, a)) - SW'(step[a])
                                     : SW'(coord_at(mul_p_reg, a)) + SW'(step[a]);
            if (sum[a][SW-1:CW-1] == '0 || sum[a][SW-1:CW-1] == '1)
                res_next[a] = sum[a][CW-1:0];
            else if (sum[a][SW-1])
                res_next[a] = {1'b1, {(CW-1){1'b0}}};
            else
                res_next[a] = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= mul_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
            res_reg[a] <= res_next[a];
    end

    assign done = out_vld_reg;
    assign e    = '{x: res_reg[0], y: res_reg[1], z: res_reg[2]};

endmodule

FILE: sv/triangle_plane_clipper_core.sv
// Top level of the triangle plane clipper: config registers, distance pipe, output sequencer.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------
//  config    | in/out    | psel/penable/pwrite, pready | paddr, pwdata, prdata
//  item      | in        | start, busy                | item   (tpc_pkg::item_t)
//  result    | out       | strobe (no back-pressure)  | result (tpc_pkg::result_t)
//
// A new triangle is not taken back to back: busy rises for the cycle after each
// transfer, since one triangle may give two results over the single result port.
// Results leave through the input, product, sum, 19-stage cut lanes and output
// register; the second of a pair follows in the next cycle.
// The 32-bit edge parameter comes from two restoring dividers, two bits per stage.
// Reset clears all valid bits and loads the plane registers with their reset values.
// The receiver cannot stall, so the pipe never holds; busy is the only throttle.
module triangle_plane_clipper_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpc_pkg::AW-1:0]      paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  tpc_pkg::item_t              item,
    output logic                        strobe,
    output tpc_pkg::result_t            result
);
    import tpc_pkg::*;

    typedef struct packed {
        mode_t                mode;
        vertex_t              v0;
        vertex_t              v1;
        vertex_t              v2;
        logic [COLOR_W-1:0]   color;
    } side_t;

    function automatic result_t make_tri(vertex_t a, vertex_t b, vertex_t c,
                                         logic [COLOR_W-1:0] color, logic last);
        result_t r;
        r.out_a_x   = a.x;
        r.out_a_y   = a.y;
        r.out_a_z   = a.z;
        r.out_b_x   = b.x;
        r.out_b_y   = b.y;
        r.out_b_z   = b.z;
        r.out_c_x   = c.x;
        r.out_c_y   = c.y;
        r.out_c_z   = c.z;
        r.out_color = color;
        r.run_last  = last;
        return r;
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg, off_reg;
    logic                 cfg_wr;
    logic [RW-1:0]        cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[AW-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= NZ_RESET;
            off_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_NORMAL_X: nx_reg  <= pwdata;
                REG_NORMAL_Y: ny_reg  <= pwdata;
                REG_NORMAL_Z: nz_reg  <= pwdata;
                REG_OFFSET:   off_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_NORMAL_X: prdata = nx_reg;
            REG_NORMAL_Y: prdata = ny_reg;
            REG_NORMAL_Z: prdata = nz_reg;
            REG_OFFSET:   prdata = off_reg;
        endcase
    end

    // ---------------- input stage ----------------
    logic  accept;
    logic  a_vld_reg;
    item_t a_item_reg;

    // one transfer, then busy holds off the next to leave room for a second result
    assign busy   = a_vld_reg;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            a_item_reg <= item;
    end

    // ---------------- product stage ----------------
    vertex_t              a_vtx [3];
    logic signed [NW-1:0] nrm   [3];
    logic                 b_vld_reg;
    logic signed [PW-1:0] b_prod_reg [3][3];
    vertex_t              b_vtx_reg  [3];
    logic [COLOR_W-1:0]   b_color_reg;

    always_comb
    begin
        a_vtx[0] = '{x: a_item_reg.a_x, y: a_item_reg.a_y, z: a_item_reg.a_z};
        a_vtx[1] = '{x: a_item_reg.b_x, y: a_item_reg.b_y, z: a_item_reg.b_z};
        a_vtx[2] = '{x: a_item_reg.c_x, y: a_item_reg.c_y, z: a_item_reg.c_z};
        nrm[0]   = nx_reg;
        nrm[1]   = ny_reg;
        nrm[2]   = nz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 3; v++)
        begin
            b_vtx_reg[v] <= a_vtx[v];
            for (int a = 0; a < 3; a++)
                b_prod_reg[v][a] <= PW'(nrm[a]) * PW'(coord_at(a_vtx[v], a));
        end
        b_color_reg <= a_item_reg.tri_color;
    end

    // ---------------- distance stage ----------------
    dist_t              off_term;
    logic               c_vld_reg;
    dist_t              c_dist_reg [3];
    vertex_t            c_vtx_reg  [3];
    logic [COLOR_W-1:0] c_color_reg;

    // offset moves from 16 to 46 fraction bits to line up with the products
    assign off_term = {{(DW-NW-NF){off_reg[NW-1]}}, off_reg, {NF{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 3; v++)
        begin
            c_dist_reg[v] <= off_term + DW'(b_prod_reg[v][0]) + DW'(b_prod_reg[v][1])
                             + DW'(b_prod_reg[v][2]);
            c_vtx_reg[v]  <= b_vtx_reg[v];
        end
        c_color_reg <= b_color_reg;
    end

    // ---------------- classify and steer the cut lanes ----------------
    logic [2:0] keep;
    mode_t      mode;
    logic [1:0] pi0, qi0, pi1, qi1;
    side_t      side_next;

    always_comb
    begin
        for (int v = 0; v < 3; v++)
            keep[v] = !c_dist_reg[v][DW-1];
        mode = MODE_CULL;
        pi0  = 2'd0;
        qi0  = 2'd0;
        pi1  = 2'd1;
        qi1  = 2'd0;
        unique case (keep)
            3'b111: mode = MODE_PASS;
            3'b011: begin mode = MODE_TWO; pi0 = 2'd0; pi1 = 2'd1; qi0 = 2'd2; qi1 = 2'd2; end
            3'b101: begin mode = MODE_TWO; pi0 = 2'd0; pi1 = 2'd2; qi0 = 2'd1; qi1 = 2'd1; end
            3'b110: begin mode = MODE_TWO; pi0 = 2'd1; pi1 = 2'd2; qi0 = 2'd0; qi1 = 2'd0; end
            3'b001: begin mode = MODE_ONE; pi0 = 2'd0; pi1 = 2'd0; qi0 = 2'd1; qi1 = 2'd2; end
            3'b010: begin mode = MODE_ONE; pi0 = 2'd1; pi1 = 2'd1; qi0 = 2'd0; qi1 = 2'd2; end
            3'b100: begin mode = MODE_ONE; pi0 = 2'd2; pi1 = 2'd2; qi0 = 2'd0; qi1 = 2'd1; end
            3'b000: mode = MODE_CULL;
        endcase
        side_next.mode  = mode;
        side_next.v0    = c_vtx_reg[pi0];
        side_next.v1    = c_vtx_reg[pi1];
        side_next.v2    = c_vtx_reg[2];
        side_next.color = c_color_reg;
    end

    logic    lane0_done, lane1_done;
    vertex_t e0, e1;

    tpc_cut u_cut0 (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (c_vld_reg),
        .p     (c_vtx_reg[pi0]),
        .q     (c_vtx_reg[qi0]),
        .d0    (c_dist_reg[pi0]),
        .d1    (c_dist_reg[qi0]),
        .done  (lane0_done),
        .e     (e0)
    );

    tpc_cut u_cut1 (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (c_vld_reg),
        .p     (c_vtx_reg[pi1]),
        .q     (c_vtx_reg[qi1]),
        .d0    (c_dist_reg[pi1]),
        .d1    (c_dist_reg[qi1]),
        .done  (lane1_done),
        .e     (e1)
    );

    // ---------------- side line, same depth as the cut lanes ----------------
    logic  side_vld_reg [CUT_LAT];
    side_t side_reg     [CUT_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CUT_LAT; k++)
                side_vld_reg[k] <= 1'b0;
        end
        else
        begin
            side_vld_reg[0] <= c_vld_reg;
            for (int k = 1; k < CUT_LAT; k++)
                side_vld_reg[k] <= side_vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int k = 1; k < CUT_LAT; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // ---------------- output sequencer ----------------
    logic    sv;
    side_t   s;
    logic    strobe_reg, strobe_next;
    result_t result_reg, result_next;
    logic    pend_reg, pend_next;
    result_t pend_tri_reg, pend_tri_next;

    assign sv = side_vld_reg[CUT_LAT-1];
    assign s  = side_reg[CUT_LAT-1];

    always_comb
    begin
        strobe_next   = 1'b0;
        result_next   = result_reg;
        pend_next     = 1'b0;
        pend_tri_next = pend_tri_reg;
        priority if (pend_reg)
        begin
            // second triangle of a two-kept split
            strobe_next = 1'b1;
            result_next = pend_tri_reg;
        end
        else if (sv)
        begin
            unique case (s.mode)
                MODE_PASS:
                begin
                    strobe_next = 1'b1;
                    result_next = make_tri(s.v0, s.v1, s.v2, s.color, 1'b1);
                end
                MODE_ONE:
                begin
                    strobe_next = 1'b1;
                    result_next = make_tri(s.v0, e0, e1, s.color, 1'b1);
                end
                MODE_TWO:
                begin
                    strobe_next   = 1'b1;
                    result_next   = make_tri(s.v0, s.v1, e0, s.color, 1'b0);
                    pend_next     = 1'b1;
                    pend_tri_next = make_tri(s.v1, e1, e0, s.color, 1'b1);
                end
                MODE_CULL:
                begin
                    // drop: nothing survives
                    strobe_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        pend_tri_reg <= pend_tri_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not follow a transfer");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (lane0_done == sv) && (lane1_done == sv))
        else $error("cut lanes out of step with side line");

    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !sv)
        else $error("new triangle arrived while a second result was pending");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.run_last) |=> (strobe && result.run_last))
        else $error("first of a pair not followed by the last result");
`endif

endmodule
